FILE: rtl/core/bez_pkg.sv
// bez_pkg: shared constants and register codes for the bezier extremum solver
// used by every module under rtl/core
`timescale 1ns / 1ps
package bez_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int T_FRACTION_BITS_DEF = 16;
    localparam int TOL_WIDTH           = 8;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd1;
    localparam int CFG_DATA_WIDTH      = 32;
    localparam int CFG_ADDR_WIDTH      = 3;

    typedef enum logic
    {
        REG_EQUAL_TOLERANCE = 1'b0,
        REG_UNUSED          = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        MODE_QUADRATIC = 1'b0,
        MODE_CUBIC     = 1'b1
    } curve_mode_t;

endpackage

FILE: rtl/core/bez_mul.sv
// bez_mul: unsigned multiplier cut into half-width partial products, two stages
// depends on bez_pkg
`timescale 1ns / 1ps
module bez_mul #(
    parameter int WIDTH = 36
) (
    input  logic               clk,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [2*WIDTH-1:0] product
);
    import bez_pkg::*;

    localparam int LW = (WIDTH + 1) / 2;
    localparam int HW = WIDTH - LW;

    logic [2*LW-1:0]    ll_reg;
    logic [LW+HW-1:0]   lh_reg;
    logic [LW+HW-1:0]   hl_reg;
    logic [2*HW-1:0]    hh_reg;
    logic [2*WIDTH-1:0] product_reg;
    logic [2*WIDTH-1:0] product_next;

    always_ff @(posedge clk)
    begin
        ll_reg <= a[LW-1:0] * b[LW-1:0];
        lh_reg <= a[LW-1:0] * b[WIDTH-1:LW];
        hl_reg <= a[WIDTH-1:LW] * b[LW-1:0];
        hh_reg <= a[WIDTH-1:LW] * b[WIDTH-1:LW];
        product_reg <= product_next;
    end

    always_comb
    begin
        product_next = (2*WIDTH)'(ll_reg)
                     + ((2*WIDTH)'(lh_reg) << LW)
                     + ((2*WIDTH)'(hl_reg) << LW)
                     + ((2*WIDTH)'(hh_reg) << (2*LW));
    end

    assign product = product_reg;

endmodule

FILE: rtl/core/bez_isqrt.sv
// bez_isqrt: pipelined floor square root, one result bit per register stage
// depends on bez_pkg; carries a sideband vector alongside the data
`timescale 1ns / 1ps
module bez_isqrt #(
    parameter int DW  = 80,
    parameter int SBW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [DW-1:0]       radicand,
    input  logic [SBW-1:0]      in_side,
    output logic                out_valid,
    output logic [DW/2-1:0]     root,
    output logic [SBW-1:0]      out_side
);
    import bez_pkg::*;

    localparam int SW = DW / 2;

    logic           valid_reg [SW];
    logic [DW-1:0]  rem_reg   [SW];
    logic [SW-1:0]  root_reg  [SW];
    logic [SBW-1:0] side_reg  [SW];

    genvar k;
    generate
        for (k = 0; k < SW; k++)
        begin : g_stage
            localparam int BIT = SW - 1 - k;
            logic           v_prev;
            logic [DW-1:0]  rem_prev;
            logic [SW-1:0]  root_prev;
            logic [SBW-1:0] side_prev;
            logic [DW-1:0]  trial;
            logic [DW-1:0]  rem_next;
            logic [SW-1:0]  root_next;

            if (k == 0)
            begin : g_first
                assign v_prev    = in_valid;
                assign rem_prev  = radicand;
                assign root_prev = '0;
                assign side_prev = in_side;
            end
            else
            begin : g_rest
                assign v_prev    = valid_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            always_comb
            begin
                trial = (DW'(root_prev) << (BIT + 1)) | (DW'(1) << (2 * BIT));
                if (rem_prev >= trial)
                begin
                    rem_next  = rem_prev - trial;
                    root_next = root_prev | (SW'(1) << BIT);
                end
                else
                begin
                    rem_next  = rem_prev;
                    root_next = root_prev;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    endgenerate

    assign out_valid = valid_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign out_side  = side_reg[SW-1];

endmodule

FILE: rtl/core/bez_udiv.sv
// bez_udiv: two-lane pipelined restoring fraction divider, one quotient bit per stage
// depends on bez_pkg; operands arrive normalised with 0 < n < d
`timescale 1ns / 1ps
module bez_udiv #(
    parameter int UW = 37,
    parameter int TF = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_ok,
    input  logic [UW-1:0] num [2],
    input  logic [UW-1:0] den [2],
    output logic          out_valid,
    output logic [1:0]    out_ok,
    output logic [TF-1:0] quot [2]
);
    import bez_pkg::*;

    logic          valid_reg [TF];
    logic [1:0]    ok_reg    [TF];
    logic [UW-1:0] rem_reg   [TF][2];
    logic [UW-1:0] den_reg   [TF][2];
    logic [TF-1:0] q_reg     [TF][2];

    genvar k, l;
    generate
        for (k = 0; k < TF; k++)
        begin : g_stage
            logic v_prev;
            logic [1:0] ok_prev;

            if (k == 0)
            begin : g_first_ctl
                assign v_prev  = in_valid;
                assign ok_prev = in_ok;
            end
            else
            begin : g_rest_ctl
                assign v_prev  = valid_reg[k-1];
                assign ok_prev = ok_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                    ok_reg[k]    <= '0;
                end
                else
                begin
                    valid_reg[k] <= v_prev;
                    ok_reg[k]    <= ok_prev;
                end
            end

            for (l = 0; l < 2; l++)
            begin : g_lane
                logic [UW-1:0] rem_prev;
                logic [UW-1:0] den_prev;
                logic [TF-1:0] q_prev;
                logic [UW:0]   shifted;
                logic          ge;
                logic [UW-1:0] rem_next;

                if (k == 0)
                begin : g_first
                    assign rem_prev = num[l];
                    assign den_prev = den[l];
                    assign q_prev   = '0;
                end
                else
                begin : g_rest
                    assign rem_prev = rem_reg[k-1][l];
                    assign den_prev = den_reg[k-1][l];
                    assign q_prev   = q_reg[k-1][l];
                end

                always_comb
                begin
                    shifted  = {rem_prev, 1'b0};
                    ge       = shifted >= {1'b0, den_prev};
                    rem_next = ge ? UW'(shifted - {1'b0, den_prev}) : UW'(shifted);
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[k][l] <= rem_next;
                    den_reg[k][l] <= den_prev;
                    q_reg[k][l]   <= {q_prev[TF-2:0], ge};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[TF-1];
    assign out_ok    = ok_reg[TF-1];
    assign quot[0]   = q_reg[TF-1][0];
    assign quot[1]   = q_reg[TF-1][1];

endmodule

FILE: rtl/core/bezier_extrema_solver_core.sv
// bezier_extrema_solver_core: top level of the bezier derivative root solver
// depends on bez_pkg, bez_mul, bez_isqrt and bez_udiv
`timescale 1ns / 1ps
// Finds the parameters t in (0,1) where a quadratic (action 0) or cubic (action 1)
// Bezier coordinate has zero derivative. busy is always low: a curve is taken on
// every cycle that start is high, and each produces exactly one transaction on
// result_valid after the coefficient, multiplier, discriminant, one-bit-per-stage
// square root, operand, one-bit-per-stage divider and output register stages.
// The result cannot be held off, so it must be taken on the cycle it appears.
// equal_tolerance sits at byte address 0 and should only be written while idle.
module bezier_extrema_solver_core #(
    parameter int COORD_WIDTH     = bez_pkg::COORD_WIDTH_DEF,
    parameter int T_FRACTION_BITS = bez_pkg::T_FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bez_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
    input  logic [bez_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [bez_pkg::CFG_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [COORD_WIDTH-1:0]              p0,
    input  logic [COORD_WIDTH-1:0]              p1,
    input  logic [COORD_WIDTH-1:0]              p2,
    input  logic [COORD_WIDTH-1:0]              p3,
    output logic                                result_valid,
    output logic [1:0]                          root_count,
    output logic [T_FRACTION_BITS-1:0]          t_first,
    output logic [T_FRACTION_BITS-1:0]          t_second
);
    import bez_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int TF  = T_FRACTION_BITS;
    localparam int AW  = CW + 4;
    localparam int DW  = 2 * AW;
    localparam int OW  = AW + 2;
    localparam int UW  = OW - 1;
    localparam int SBW = 3 + 3 * AW;

    // configuration
    logic [TOL_WIDTH-1:0] tol_reg;
    reg_index_t           cfg_idx;

    assign cfg_idx = reg_index_t'(paddr[2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign prdata  = (cfg_idx == REG_EQUAL_TOLERANCE) ? CFG_DATA_WIDTH'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_idx == REG_EQUAL_TOLERANCE)
        begin
            tol_reg <= pwdata[TOL_WIDTH-1:0];
        end
    end

    // stage 1: derivative coefficients
    logic signed [AW-1:0] e0, e1, e2, e3;
    logic signed [AW-1:0] a_next, b_next, c_next;
    logic                 v1_reg;
    curve_mode_t          mode1_reg;
    logic signed [AW-1:0] a1_reg, b1_reg, c1_reg;

    always_comb
    begin
        e0 = {{4{p0[CW-1]}}, p0};
        e1 = {{4{p1[CW-1]}}, p1};
        e2 = {{4{p2[CW-1]}}, p2};
        e3 = {{4{p3[CW-1]}}, p3};
        a_next = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
        b_next = (e0 - e1 - e1 + e2) <<< 1;
        c_next = e1 - e0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= curve_mode_t'(action);
        a1_reg    <= a_next;
        b1_reg    <= b_next;
        c1_reg    <= c_next;
    end

    // stages 2-3: B^2 and A*C magnitudes
    logic [AW-1:0] mag_a, mag_b, mag_c;
    logic [DW-1:0] b_sq, ac_mag;

    assign mag_a = a1_reg[AW-1] ? AW'(-a1_reg) : AW'(a1_reg);
    assign mag_b = b1_reg[AW-1] ? AW'(-b1_reg) : AW'(b1_reg);
    assign mag_c = c1_reg[AW-1] ? AW'(-c1_reg) : AW'(c1_reg);

    bez_mul #(.WIDTH(AW)) u_mul_bb (.clk(clk), .a(mag_b), .b(mag_b), .product(b_sq));
    bez_mul #(.WIDTH(AW)) u_mul_ac (.clk(clk), .a(mag_a), .b(mag_c), .product(ac_mag));

    logic                 v2_reg, v3_reg;
    curve_mode_t          mode2_reg, mode3_reg;
    logic signed [AW-1:0] a2_reg, b2_reg, c2_reg, a3_reg, b3_reg, c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode2_reg <= mode1_reg;
        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        c2_reg    <= c1_reg;
        mode3_reg <= mode2_reg;
        a3_reg    <= a2_reg;
        b3_reg    <= b2_reg;
        c3_reg    <= c2_reg;
    end

    // stage 4: discriminant
    logic [DW-1:0] four_ac, disc_next;
    logic          same_sign, neg_next;
    logic          v4_reg;
    logic [DW-1:0] disc_reg;
    logic [SBW-1:0] side4_reg;

    always_comb
    begin
        four_ac   = {ac_mag[DW-3:0], 2'b00};
        same_sign = (a3_reg > 0 && c3_reg > 0) || (a3_reg < 0 && c3_reg < 0);
        neg_next  = same_sign && (four_ac > b_sq);
        disc_next = same_sign ? b_sq - four_ac : b_sq + four_ac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        disc_reg  <= neg_next ? '0 : disc_next;
        side4_reg <= {mode3_reg, (a3_reg == '0), neg_next, a3_reg, b3_reg, c3_reg};
    end

    // square root pipeline
    logic           v5;
    logic [AW-1:0]  s_root;
    logic [SBW-1:0] side5;

    bez_isqrt #(.DW(DW), .SBW(SBW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v4_reg),
        .radicand (disc_reg),
        .in_side  (side4_reg),
        .out_valid(v5),
        .root     (s_root),
        .out_side (side5)
    );

    // divider operand selection and sign normalisation
    logic                 mode5_bit;
    curve_mode_t          mode5;
    logic                 azero5, neg5;
    logic signed [AW-1:0] a5, b5, c5;
    logic signed [OW-1:0] ax, bx, cx, sx, q2;
    logic signed [OW-1:0] n_sel [2];
    logic signed [OW-1:0] d_sel [2];
    logic signed [OW-1:0] n_nrm [2];
    logic signed [OW-1:0] d_nrm [2];
    logic [1:0]           en_sel, ok_next;
    logic                 v6_reg;
    logic [1:0]           ok6_reg;
    logic [UW-1:0]        n6_reg [2];
    logic [UW-1:0]        d6_reg [2];

    assign {mode5_bit, azero5, neg5, a5, b5, c5} = side5;
    assign mode5 = curve_mode_t'(mode5_bit);

    always_comb
    begin
        ax = {{2{a5[AW-1]}}, a5};
        bx = {{2{b5[AW-1]}}, b5};
        cx = {{2{c5[AW-1]}}, c5};
        sx = {2'b00, s_root};
        q2 = (bx < 0) ? sx - bx : -(bx + sx);
        n_sel[0] = -cx;
        d_sel[0] = bx;
        n_sel[1] = cx <<< 1;
        d_sel[1] = q2;
        en_sel   = 2'b01;
        if (mode5 == MODE_QUADRATIC)
        begin
            d_sel[0] = bx >>> 1;
        end
        else if (azero5)
        begin
            en_sel = 2'b01;
        end
        else if (neg5)
        begin
            en_sel = 2'b00;
        end
        else
        begin
            n_sel[0] = q2;
            d_sel[0] = ax <<< 1;
            en_sel   = 2'b11;
        end
        for (int i = 0; i < 2; i++)
        begin
            n_nrm[i] = n_sel[i][OW-1] ? -n_sel[i] : n_sel[i];
            d_nrm[i] = n_sel[i][OW-1] ? -d_sel[i] : d_sel[i];
            ok_next[i] = en_sel[i] && d_nrm[i] != '0 && n_nrm[i] != '0
                       && n_nrm[i] < d_nrm[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg  <= 1'b0;
            ok6_reg <= '0;
        end
        else
        begin
            v6_reg  <= v5;
            ok6_reg <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            n6_reg[i] <= n_nrm[i][UW-1:0];
            d6_reg[i] <= d_nrm[i][UW-1:0];
        end
    end

    // fraction dividers
    logic          v7;
    logic [1:0]    ok7;
    logic [TF-1:0] q7 [2];

    bez_udiv #(.UW(UW), .TF(TF)) u_udiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v6_reg),
        .in_ok    (ok6_reg),
        .num      (n6_reg),
        .den      (d6_reg),
        .out_valid(v7),
        .out_ok   (ok7),
        .quot     (q7)
    );

    // root packing and double-root merge
    logic          r0_ok, r1_ok;
    logic [TF-1:0] diff;
    logic [1:0]    count_next;
    logic [TF-1:0] first_next, second_next;
    logic          valid_reg;
    logic [1:0]    count_reg;
    logic [TF-1:0] first_reg, second_reg;

    always_comb
    begin
        r0_ok = ok7[0] && q7[0] != '0;
        r1_ok = ok7[1] && q7[1] != '0;
        diff  = (q7[0] > q7[1]) ? q7[0] - q7[1] : q7[1] - q7[0];
        count_next  = 2'd0;
        first_next  = '0;
        second_next = '0;
        if (r0_ok && r1_ok)
        begin
            first_next = q7[0];
            if (diff <= TF'(tol_reg))
            begin
                count_next = 2'd1;
            end
            else
            begin
                count_next  = 2'd2;
                second_next = q7[1];
            end
        end
        else if (r0_ok)
        begin
            count_next = 2'd1;
            first_next = q7[0];
        end
        else if (r1_ok)
        begin
            count_next = 2'd1;
            first_next = q7[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= v7;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign result_valid = valid_reg;
    assign root_count   = count_reg;
    assign t_first      = first_reg;
    assign t_second     = second_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> root_count != 2'd3)
        else $error("root count out of range");
    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && root_count == 2'd0 |-> t_first == '0 && t_second == '0)
        else $error("roots reported with zero count");
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && root_count != 2'd2 |-> t_second == '0)
        else $error("second root without count of two");
    a_first_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && root_count != 2'd0 |-> t_first != '0)
        else $error("zero root reported as valid");
    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && root_count == 2'd2 |-> t_first != t_second)
        else $error("double root not merged");
`endif

endmodule
